// ===== sv/hfjm_pkg.sv =====
// Package: types, constants and helpers for the HID field to joystick mapper.
`timescale 1ns / 1ps
package hfjm_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int BTN_IDX_W = $clog2(NUM_BUTTONS);

  localparam logic [15:0] PAGE_DESKTOP  = 16'h0001;
  localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
  localparam logic [15:0] PAGE_BUTTON   = 16'h0009;

  localparam logic [15:0] USE_X     = 16'h0030;
  localparam logic [15:0] USE_Y     = 16'h0031;
  localparam logic [15:0] USE_HAT   = 16'h0039;
  localparam logic [15:0] USE_DP_UP = 16'h0090;
  localparam logic [15:0] USE_DP_DN = 16'h0091;
  localparam logic [15:0] USE_DP_RT = 16'h0092;
  localparam logic [15:0] USE_DP_LT = 16'h0093;

  localparam logic [7:0] HAT_CENTER = 8'hff;
  localparam logic [10:0] THRESHOLD_RESET = 11'd256;
  localparam logic [1:0] DEST_PORT_A = 2'd0;
  localparam logic [1:0] DEST_PORT_B = 2'd1;
  localparam logic [1:0] DEST_MOUSE = 2'd2;

  localparam logic [1:0] REG_PORT = 2'd0;
  localparam logic [1:0] REG_KIND = 2'd1;
  localparam logic [1:0] REG_THR  = 2'd2;

  localparam logic [1:0] PORT_NONE = 2'd0;
  localparam logic [1:0] PORT_A    = 2'd1;
  localparam logic [1:0] KIND_JOY   = 2'd0;
  localparam logic [1:0] KIND_MOUSE = 2'd1;

  // dpad bit order
  localparam int D_UP = 0;
  localparam int D_DOWN = 1;
  localparam int D_RIGHT = 2;
  localparam int D_LEFT = 3;

  // mask bit order
  localparam int M_X = 0;
  localparam int M_Y = 1;
  localparam int M_HAT = 2;
  localparam int M_DPAD = 3;
  localparam int M_B0 = 4;
  localparam int M_B1 = 5;

  typedef struct packed {
    logic               carries_field;
    logic [15:0]        hid_page;
    logic [15:0]        usage_code;
    logic signed [31:0] field_value;
    logic signed [31:0] logical_min;
    logic signed [31:0] logical_max;
    logic [5:0]         bits_per_field;
    logic               report_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         destination;
    logic               dir_up;
    logic               dir_down;
    logic               dir_left;
    logic               dir_right;
    logic               fire_pressed;
    logic signed [31:0] mouse_x;
    logic signed [31:0] mouse_y;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_AXIS_X, OP_AXIS_Y, OP_HAT, OP_DPAD, OP_BUTTON
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [3:0]          dpad_sel;
    logic [BTN_IDX_W-1:0] btn_idx;
    logic                on;
    logic signed [32:0]  range;
    logic signed [32:0]  centered;
    logic [7:0]          hat;
    logic                report_end;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_SAT, ST_END, ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  port_assignment;
    logic [1:0]  device_kind;
    logic [10:0] dir_threshold;
  } cfg_t;

endpackage

// ===== sv/hfjm_front.sv =====
// Front end: decodes usages into commands and precomputes axis range and offset.
`timescale 1ns / 1ps
module hfjm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hfjm_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output hfjm_pkg::cmd_t     cmd_data
);

  hfjm_pkg::cmd_t c;
  logic signed [32:0] hi;
  logic signed [32:0] lo;
  logic signed [32:0] val;
  logic signed [32:0] rng;
  logic [15:0] bidx;

  always_comb begin
    lo = {in_data.logical_min[31], in_data.logical_min};
    val = {in_data.field_value[31], in_data.field_value};
    hi = {in_data.logical_max[31], in_data.logical_max};
    if (in_data.logical_max == -32'sd1) begin
      if (in_data.bits_per_field >= 6'd31) hi = 33'sh07fffffff;
      else hi = 33'sd1 <<< in_data.bits_per_field[4:0];
      if (in_data.bits_per_field < 6'd31) hi = hi - 33'sd1;
    end
    rng = hi - lo;
    bidx = in_data.usage_code - 16'd1;
    c = '0;
    c.op = hfjm_pkg::OP_NONE;
    c.on = (in_data.field_value != 32'sd0);
    c.range = rng;
    c.centered = val - (rng >>> 1) - lo;
    if (rng < 0 && rng[0]) c.centered = val - ((rng + 33'sd1) >>> 1) - lo;
    c.report_end = in_data.report_end;
    // hat range check uses the maximum as given, without full-scale substitution
    if ((in_data.field_value < in_data.logical_min) ||
        (in_data.field_value > in_data.logical_max)) c.hat = hfjm_pkg::HAT_CENTER;
    else c.hat = in_data.field_value[7:0] - in_data.logical_min[7:0];
    if (in_data.carries_field) begin
      case (in_data.hid_page)
        hfjm_pkg::PAGE_DESKTOP: begin
          case (in_data.usage_code)
            hfjm_pkg::USE_X:     c.op = hfjm_pkg::OP_AXIS_X;
            hfjm_pkg::USE_Y:     c.op = hfjm_pkg::OP_AXIS_Y;
            hfjm_pkg::USE_HAT:   c.op = hfjm_pkg::OP_HAT;
            hfjm_pkg::USE_DP_UP: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_UP] = 1'b1;
            end
            hfjm_pkg::USE_DP_DN: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_DOWN] = 1'b1;
            end
            hfjm_pkg::USE_DP_RT: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_RIGHT] = 1'b1;
            end
            hfjm_pkg::USE_DP_LT: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_LEFT] = 1'b1;
            end
            default: c.op = hfjm_pkg::OP_NONE;
          endcase
        end
        hfjm_pkg::PAGE_KEYBOARD: begin
          case (in_data.usage_code) inside
            16'h004f, 16'h005e: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_RIGHT] = 1'b1;
            end
            16'h0050, 16'h005c: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_LEFT] = 1'b1;
            end
            16'h0051, 16'h005a: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_DOWN] = 1'b1;
            end
            16'h0052, 16'h0060: begin
              c.op = hfjm_pkg::OP_DPAD; c.dpad_sel[hfjm_pkg::D_UP] = 1'b1;
            end
            16'h001d, 16'h0028, 16'h002c, 16'h0058: begin
              c.op = hfjm_pkg::OP_BUTTON; c.btn_idx = '0;
            end
            default: c.op = hfjm_pkg::OP_NONE;
          endcase
        end
        hfjm_pkg::PAGE_BUTTON: begin
          if (bidx < 16'(hfjm_pkg::NUM_BUTTONS)) begin
            c.op = hfjm_pkg::OP_BUTTON;
            c.btn_idx = bidx[hfjm_pkg::BTN_IDX_W-1:0];
          end
        end
        default: c.op = hfjm_pkg::OP_NONE;
      endcase
    end
  end

  // two-entry queue between front and back
  hfjm_pkg::cmd_t q [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;

  assign in_ready = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd_data = q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wp] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (cmd_valid && cmd_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");
  a_full_noready: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !in_ready) else $error("ready while full");
  a_empty_novalid: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0) |-> !cmd_valid) else $error("valid while empty");

endmodule

// ===== sv/hfjm_div.sv =====
// Iterative restoring divider: signed 45-bit dividend by signed 33-bit divisor.
`timescale 1ns / 1ps
module hfjm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [44:0] dividend,
  input  logic signed [32:0] divisor,
  output logic               done,
  output logic signed [44:0] quotient
);

  logic [44:0] rem_q;
  logic [44:0] quo;
  logic [32:0] dvs;
  logic        neg;
  logic [5:0]  step;
  logic        busy;
  logic [45:0] trial;
  logic [44:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q[43:0], quo[44]};
    trial = {1'b0, rem_sh} - {13'd0, dvs};
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; step <= 6'd0;
        rem_q <= '0;
        quo <= dividend[44] ? 45'(-dividend) : dividend;
        dvs <= divisor[32] ? 33'(-divisor) : divisor;
        neg <= dividend[44] ^ divisor[32];
      end else if (busy) begin
        if (!trial[45]) begin
          rem_q <= trial[44:0]; quo <= {quo[43:0], 1'b1};
        end else begin
          rem_q <= rem_sh; quo <= {quo[43:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'd44) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/hfjm_back.sv =====
// Back end: updates gamepad state, runs axis scaling and builds report-end results.
`timescale 1ns / 1ps
module hfjm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  hfjm_pkg::cmd_t    cmd_data,
  input  hfjm_pkg::cfg_t    cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output hfjm_pkg::out_item_t out_data
);

  hfjm_pkg::back_state_t state;
  hfjm_pkg::back_state_t state_next;

  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic [7:0]  hat_position;
  logic [3:0]  dpad_bits;
  logic [hfjm_pkg::NUM_BUTTONS-1:0] button_bits;
  logic [5:0]  updated_mask;
  hfjm_pkg::cmd_t cur;
  logic signed [44:0] prod;
  logic div_start;
  logic div_done;
  logic signed [44:0] quo;
  logic signed [31:0] sat;
  hfjm_pkg::out_item_t res;
  logic res_ok;
  logic up, down, left, right, fire;
  logic signed [11:0] thr;

  hfjm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(cur.range), .done(div_done), .quotient(quo)
  );

  always_comb begin
    if (quo > 45'sh0007fffffff) sat = 32'sh7fffffff;
    else if (quo < -45'sh00080000000) sat = 32'sh80000000;
    else sat = quo[31:0];
  end

  always_comb begin
    thr = $signed({1'b0, cfg.dir_threshold});
    up = 1'b0; down = 1'b0; left = 1'b0; right = 1'b0; fire = 1'b0;
    if (updated_mask[hfjm_pkg::M_HAT]) begin
      case (hat_position)
        8'd0: up = 1'b1;
        8'd1: begin up = 1'b1; right = 1'b1; end
        8'd2: right = 1'b1;
        8'd3: begin right = 1'b1; down = 1'b1; end
        8'd4: down = 1'b1;
        8'd5: begin down = 1'b1; left = 1'b1; end
        8'd6: left = 1'b1;
        8'd7: begin left = 1'b1; up = 1'b1; end
        default: ;
      endcase
    end
    if (updated_mask[hfjm_pkg::M_DPAD]) begin
      up = up | dpad_bits[hfjm_pkg::D_UP];
      down = down | dpad_bits[hfjm_pkg::D_DOWN];
      right = right | dpad_bits[hfjm_pkg::D_RIGHT];
      left = left | dpad_bits[hfjm_pkg::D_LEFT];
    end
    if (updated_mask[hfjm_pkg::M_B0]) fire = button_bits[0];
    if (updated_mask[hfjm_pkg::M_B1] && button_bits[1]) up = 1'b1;
    if (updated_mask[hfjm_pkg::M_X]) begin
      if (axis_x < -32'(thr)) left = 1'b1;
      if (axis_x > 32'(thr)) right = 1'b1;
    end
    if (updated_mask[hfjm_pkg::M_Y]) begin
      if (axis_y < -32'(thr)) up = 1'b1;
      if (axis_y > 32'(thr)) down = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready = 1'b0;
    div_start = 1'b0;
    case (state)
      hfjm_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if ((cmd_data.op == hfjm_pkg::OP_AXIS_X || cmd_data.op == hfjm_pkg::OP_AXIS_Y)
              && cmd_data.range != 33'sd0)
            state_next = hfjm_pkg::ST_MUL;
          else if (cmd_data.report_end) state_next = hfjm_pkg::ST_END;
        end
      end
      hfjm_pkg::ST_MUL: begin
        div_start = 1'b1;
        state_next = hfjm_pkg::ST_DIV;
      end
      hfjm_pkg::ST_DIV: if (div_done) state_next = hfjm_pkg::ST_SAT;
      hfjm_pkg::ST_SAT: state_next = cur.report_end ? hfjm_pkg::ST_END : hfjm_pkg::ST_IDLE;
      hfjm_pkg::ST_END: state_next = res_ok ? hfjm_pkg::ST_OUT : hfjm_pkg::ST_IDLE;
      hfjm_pkg::ST_OUT: if (out_ready) state_next = hfjm_pkg::ST_IDLE;
      default: state_next = hfjm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    res_ok = 1'b0;
    if (cfg.port_assignment != hfjm_pkg::PORT_NONE) begin
      if (cfg.device_kind == hfjm_pkg::KIND_JOY) begin
        res_ok = 1'b1;
        res.destination = (cfg.port_assignment == hfjm_pkg::PORT_A) ?
                          hfjm_pkg::DEST_PORT_A : hfjm_pkg::DEST_PORT_B;
        res.dir_up = up; res.dir_down = down; res.dir_left = left;
        res.dir_right = right; res.fire_pressed = fire;
      end else if (cfg.device_kind == hfjm_pkg::KIND_MOUSE) begin
        res_ok = 1'b1;
        res.destination = hfjm_pkg::DEST_MOUSE;
        res.mouse_x = axis_x; res.mouse_y = axis_y;
      end
    end
  end

  assign out_valid = (state == hfjm_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= hfjm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == hfjm_pkg::ST_IDLE && cmd_valid) begin
      cur <= cmd_data;
      prod <= 45'(cmd_data.centered) <<< 10;
    end
    if (state == hfjm_pkg::ST_END) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= '0; axis_y <= '0; hat_position <= hfjm_pkg::HAT_CENTER;
      dpad_bits <= '0; button_bits <= '0; updated_mask <= '0;
    end else begin
      if (state == hfjm_pkg::ST_IDLE && cmd_valid) begin
        case (cmd_data.op)
          hfjm_pkg::OP_AXIS_X: begin
            updated_mask[hfjm_pkg::M_X] <= 1'b1;
            if (cmd_data.range == 33'sd0) axis_x <= '0;
          end
          hfjm_pkg::OP_AXIS_Y: begin
            updated_mask[hfjm_pkg::M_Y] <= 1'b1;
            if (cmd_data.range == 33'sd0) axis_y <= '0;
          end
          hfjm_pkg::OP_HAT: begin
            hat_position <= cmd_data.hat;
            updated_mask[hfjm_pkg::M_HAT] <= 1'b1;
          end
          hfjm_pkg::OP_DPAD: begin
            dpad_bits <= cmd_data.on ? (dpad_bits | cmd_data.dpad_sel)
                                     : (dpad_bits & ~cmd_data.dpad_sel);
            updated_mask[hfjm_pkg::M_DPAD] <= 1'b1;
          end
          hfjm_pkg::OP_BUTTON: begin
            button_bits[cmd_data.btn_idx] <= cmd_data.on;
            if (cmd_data.btn_idx == '0) updated_mask[hfjm_pkg::M_B0] <= 1'b1;
            if (cmd_data.btn_idx == hfjm_pkg::BTN_IDX_W'(1))
              updated_mask[hfjm_pkg::M_B1] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state == hfjm_pkg::ST_SAT) begin
        if (cur.op == hfjm_pkg::OP_AXIS_X) axis_x <= sat;
        else axis_y <= sat;
      end
      // close the report
      if (state == hfjm_pkg::ST_END) updated_mask <= '0;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != hfjm_pkg::ST_IDLE) |-> !cmd_ready) else $error("request taken while busy");
  a_mask_clear: assert property (@(posedge clk) disable iff (rst)
    (state == hfjm_pkg::ST_END) |=> (updated_mask == 6'd0)) else $error("mask not cleared");

endmodule

// ===== sv/hid_field_to_joystick_mapper.sv =====
// Top level: configuration registers, front decoder and back executor.
`timescale 1ns / 1ps
// Each field request is decoded in the front and queued (two deep); the back
// takes most requests in its idle state, while an x or y axis with a nonempty
// range also runs the 45-step serial divider and then saturates.
// A report end adds the end state, then waits for any result to be taken.
module hid_field_to_joystick_mapper (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hfjm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hfjm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  hfjm_pkg::cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  hfjm_pkg::cmd_t cmd_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_assignment <= '0;
      cfg.device_kind <= '0;
      cfg.dir_threshold <= hfjm_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        hfjm_pkg::REG_PORT: cfg.port_assignment <= pwdata[1:0];
        hfjm_pkg::REG_KIND: cfg.device_kind <= pwdata[1:0];
        hfjm_pkg::REG_THR:  cfg.dir_threshold <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hfjm_pkg::REG_PORT: prdata = {30'd0, cfg.port_assignment};
      hfjm_pkg::REG_KIND: prdata = {30'd0, cfg.device_kind};
      hfjm_pkg::REG_THR:  prdata = {21'd0, cfg.dir_threshold};
      default: prdata = '0;
    endcase
  end

  hfjm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
  );

  hfjm_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_data(cmd_data), .cfg(cfg), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
